// ===== rtl/lprp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the lidar packet record parser.
// No dependencies; every other file imports this package.
package lprp_pkg;

    // Default packet geometry.
    localparam int BLOCKS_PER_PACKET_DEF = 12;
    localparam int CHANNELS_DEF          = 16;
    localparam int HEADER_BYTES_DEF      = 42;

    // Field widths fixed by the interface.
    localparam int BYTE_W = 8;
    localparam int AZ_W   = 16;
    localparam int BLK_W  = 4;
    localparam int CH_W   = 4;
    localparam int DIST_W = 16;
    localparam int REC_W  = 6;   // records per block, up to 2 x 32 channels

    // Configuration register indexes and reset values.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_LOW    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_HIGH   = 2'd2;
    localparam logic [BYTE_W-1:0] RANGE_LIMIT_RST = 8'd120;
    localparam logic [AZ_W-1:0]   WRAP_LOW_RST    = 16'd500;
    localparam logic [AZ_W-1:0]   WRAP_HIGH_RST   = 16'd35500;

    // Output beat layout: 50 bits of fields padded to 56.
    localparam int M_TDATA_W = 56;

    // What a byte means at its place in the packet.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_AZ_HI   = 3'd1;
    localparam logic [2:0] KIND_AZ_LO   = 3'd2;
    localparam logic [2:0] KIND_DIST_HI = 3'd3;
    localparam logic [2:0] KIND_DIST_LO = 3'd4;
    localparam logic [2:0] KIND_INTEN   = 3'd5;

    typedef struct packed {
        logic [2:0]        kind;
        logic [BLK_W-1:0]  blk;
        logic [REC_W-1:0]  rec;
        logic [BYTE_W-1:0] data;
    } beat_info_t;

    typedef struct packed {
        logic [BYTE_W-1:0] range_limit;
        logic [AZ_W-1:0]   wrap_low;
        logic [AZ_W-1:0]   wrap_high;
    } cfg_t;

endpackage

// ===== rtl/lprp_seq.sv =====
`timescale 1ns / 1ps
// Byte position tracking and classification, with the input register stage.
// Depends on lprp_pkg.
module lprp_seq
    import lprp_pkg::*;
#(
    parameter int BLOCKS_PER_PACKET = BLOCKS_PER_PACKET_DEF,
    parameter int CHANNELS          = CHANNELS_DEF,
    parameter int HEADER_BYTES      = HEADER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              advance,
    output logic              s1_valid,
    output beat_info_t        s1_info
);

    localparam int BLOCK_BYTES = 4 + 6 * CHANNELS;
    localparam int DATA_END    = HEADER_BYTES + BLOCKS_PER_PACKET * BLOCK_BYTES;
    localparam int POS_W       = $clog2(DATA_END + 1);
    localparam int OFF_W       = $clog2(BLOCK_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [OFF_W-1:0] off_reg, off_next, off_cur;
    logic [1:0]       phase_reg, phase_next, phase_cur;
    logic [REC_W-1:0] rec_reg, rec_next, rec_cur;
    logic [BLK_W-1:0] blk_reg, blk_next, blk_cur;
    logic             in_data;
    logic [2:0]       kind;
    logic             accept;
    logic             s1_valid_reg;
    beat_info_t       s1_info_reg;

    assign s_tready = advance || !s1_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // A start beat restarts the packet at byte zero.
    assign pos_cur   = s_tuser ? '0 : pos_reg;
    assign off_cur   = s_tuser ? '0 : off_reg;
    assign phase_cur = s_tuser ? '0 : phase_reg;
    assign rec_cur   = s_tuser ? '0 : rec_reg;
    assign blk_cur   = s_tuser ? '0 : blk_reg;

    assign in_data = ({1'b0, pos_cur} >= (POS_W + 1)'(HEADER_BYTES)) &&
                     (pos_cur < POS_W'(DATA_END));

    always_comb begin
        kind = KIND_NONE;
        if (in_data) begin
            if (off_cur == OFF_W'(2)) begin
                kind = KIND_AZ_HI;
            end else if (off_cur == OFF_W'(3)) begin
                kind = KIND_AZ_LO;
            end else if (off_cur >= OFF_W'(4)) begin
                unique case (phase_cur)
                    2'd0:    kind = KIND_DIST_HI;
                    2'd1:    kind = KIND_DIST_LO;
                    default: kind = KIND_INTEN;
                endcase
            end
        end
    end

    always_comb begin
        pos_next   = (pos_cur < POS_W'(DATA_END)) ? pos_cur + 1'b1 : POS_W'(DATA_END);
        off_next   = off_cur;
        phase_next = phase_cur;
        rec_next   = rec_cur;
        blk_next   = blk_cur;
        if (in_data) begin
            if (off_cur == OFF_W'(BLOCK_BYTES - 1)) begin
                off_next   = '0;
                phase_next = '0;
                rec_next   = '0;
                blk_next   = blk_cur + 1'b1;
            end else begin
                off_next = off_cur + 1'b1;
                if (off_cur >= OFF_W'(4)) begin
                    phase_next = (phase_cur == 2'd2) ? 2'd0 : phase_cur + 1'b1;
                    rec_next   = (phase_cur == 2'd2) ? rec_cur + 1'b1 : rec_cur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            off_reg      <= '0;
            phase_reg    <= '0;
            rec_reg      <= '0;
            blk_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pos_reg   <= pos_next;
                off_reg   <= off_next;
                phase_reg <= phase_next;
                rec_reg   <= rec_next;
                blk_reg   <= blk_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg.kind <= kind;
            s1_info_reg.blk  <= blk_cur;
            s1_info_reg.rec  <= rec_cur;
            s1_info_reg.data <= s_tdata;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;

    a_off_range : assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg < OFF_W'(BLOCK_BYTES))
        else $error("block offset out of range");
    a_phase_range : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("record phase out of range");
    a_pos_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(DATA_END))
        else $error("byte position beyond data end");

endmodule

// ===== rtl/lprp_rec.sv =====
`timescale 1ns / 1ps
// Record assembly, limit check, turn detection and the result register.
// Depends on lprp_pkg.
module lprp_rec
    import lprp_pkg::*;
#(
    parameter int BLOCKS_PER_PACKET = BLOCKS_PER_PACKET_DEF,
    parameter int CHANNELS          = CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s1_valid,
    input  beat_info_t           s1_info,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [DIST_W-1:0] rec_bytes_reg;
    logic [AZ_W-1:0]   cur_az_reg, prev_az_reg, az_word;
    logic              seen_reg, turn_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic              step, firing, over_limit;
    logic [REC_W-1:0]  chan_full;
    logic [DIST_W-1:0] dist_val;
    logic [BYTE_W-1:0] inten;

    assign advance = !m_valid_reg || m_tready;
    assign step    = advance && s1_valid;
    assign az_word = {rec_bytes_reg[15:8], s1_info.data};

    // Record index below 2*CHANNELS, so the firing is a single compare.
    assign firing    = s1_info.rec >= REC_W'(CHANNELS);
    assign chan_full = firing ? s1_info.rec - REC_W'(CHANNELS) : s1_info.rec;
    assign over_limit = rec_bytes_reg[15:8] > cfg.range_limit;
    assign dist_val = over_limit ? '0 : rec_bytes_reg;
    assign inten    = over_limit ? '0 : s1_info.data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_bytes_reg <= '0;
            cur_az_reg    <= '0;
            prev_az_reg   <= '0;
            seen_reg      <= 1'b0;
            turn_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= s1_valid && (s1_info.kind == KIND_INTEN);
            end
            if (step) begin
                unique case (s1_info.kind)
                    KIND_AZ_HI, KIND_DIST_HI: begin
                        rec_bytes_reg <= {s1_info.data, 8'h00};
                    end
                    KIND_AZ_LO: begin
                        turn_reg    <= seen_reg && (az_word < cfg.wrap_low) &&
                                       (prev_az_reg > cfg.wrap_high);
                        cur_az_reg  <= az_word;
                        prev_az_reg <= az_word;
                        seen_reg    <= 1'b1;
                    end
                    KIND_DIST_LO: begin
                        rec_bytes_reg[7:0] <= s1_info.data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && s1_info.kind == KIND_INTEN) begin
            m_data_reg <= {6'd0, turn_reg, inten, dist_val, chan_full[CH_W-1:0],
                           firing, s1_info.blk, cur_az_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_turn_needs_seen : assert property (@(posedge aclk) disable iff (!aresetn)
        turn_reg |-> seen_reg)
        else $error("turn flagged before any block azimuth");
    a_block_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_data_reg[19:16]} < (BLK_W + 1)'(BLOCKS_PER_PACKET)))
        else $error("block number beyond packet");
    a_result_after_seen : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> seen_reg)
        else $error("record emitted without a block azimuth");

endmodule

// ===== rtl/lidar_packet_record_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the lidar packet record parser: configuration registers and
// the two pipeline stages. Depends on lprp_pkg, lprp_seq and lprp_rec.
//
// Channel   Direction  Beat contents
// s_        in         tdata: data_byte[7:0]; tuser: packet_start
// m_        out        tdata: azimuth, block_number, firing, channel,
//                             distance, intensity, turn_complete
// cfg_      in         write of register cfg_addr with cfg_wdata
//
// One byte is accepted per cycle unless the result side stalls; a result
// is valid once the intensity byte of its record has passed through the
// input register and into the result register. Reset clears the packet
// position and the turn state and loads the register defaults. When the
// result register is full and not taken, the input stage still accepts
// one more beat.
module lidar_packet_record_parser_top
    import lprp_pkg::*;
#(
    parameter int BLOCKS_PER_PACKET = BLOCKS_PER_PACKET_DEF,
    parameter int CHANNELS          = CHANNELS_DEF,
    parameter int HEADER_BYTES      = HEADER_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] packet_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] azimuth, [19:16] block_number, [20] firing, [24:21] channel,
    // [40:25] distance, [48:41] intensity, [49] turn_complete, rest zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;
    logic       advance;
    logic       s1_valid;
    beat_info_t s1_info;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_limit <= RANGE_LIMIT_RST;
            cfg_reg.wrap_low    <= WRAP_LOW_RST;
            cfg_reg.wrap_high   <= WRAP_HIGH_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_RANGE_LIMIT: cfg_reg.range_limit <= cfg_wdata[BYTE_W-1:0];
                REG_WRAP_LOW:    cfg_reg.wrap_low    <= cfg_wdata;
                REG_WRAP_HIGH:   cfg_reg.wrap_high   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lprp_seq #(
        .BLOCKS_PER_PACKET(BLOCKS_PER_PACKET),
        .CHANNELS         (CHANNELS),
        .HEADER_BYTES     (HEADER_BYTES)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .advance (advance),
        .s1_valid(s1_valid),
        .s1_info (s1_info)
    );

    lprp_rec #(
        .BLOCKS_PER_PACKET(BLOCKS_PER_PACKET),
        .CHANNELS         (CHANNELS)
    ) u_rec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s1_valid(s1_valid),
        .s1_info (s1_info),
        .advance (advance),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ===== verif/lidar_packet_record_parser_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lidar_packet_record_parser_top: drives packet bytes
// on the s_ stream, predicts every record beat and checks it on the m_ stream.
// Depends on lprp_pkg and the parser RTL only.
module lidar_packet_record_parser_top_tb;
    import lprp_pkg::*;

    localparam int BLOCK_BYTES   = 4 + 6 * CHANNELS_DEF;
    localparam int DATA_END      = HEADER_BYTES_DEF + BLOCKS_PER_PACKET_DEF * BLOCK_BYTES;
    localparam int STALL_LIMIT   = 3000;
    localparam int RX_HOLD       = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BEATS   = 200;

    // One record beat, azimuth in the lowest bits as on m_tdata.
    typedef struct packed {
        logic              turn;
        logic [BYTE_W-1:0] intensity;
        logic [DIST_W-1:0] distance;
        logic [CH_W-1:0]   channel;
        logic              firing;
        logic [BLK_W-1:0]  blk;
        logic [AZ_W-1:0]   azimuth;
    } lidar_record_t;

    class record_tracker;
        logic [BYTE_W-1:0] range_limit;
        logic [AZ_W-1:0]   wrap_low;
        logic [AZ_W-1:0]   wrap_high;
        int unsigned       byte_pos;
        logic [AZ_W-1:0]   cur_az;
        logic [AZ_W-1:0]   prev_az;
        logic              seen_block;
        logic [15:0]       partial;
        int unsigned       rec_idx;
        logic              turn;
        lidar_record_t     pending_records[$];
        int                errors;
        int                checked;

        function new();
            range_limit = RANGE_LIMIT_RST;
            wrap_low    = WRAP_LOW_RST;
            wrap_high   = WRAP_HIGH_RST;
            byte_pos    = 0;
            cur_az      = '0;
            prev_az     = '0;
            seen_block  = 1'b0;
            partial     = '0;
            rec_idx     = 0;
            turn        = 1'b0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                REG_RANGE_LIMIT: range_limit = value[BYTE_W-1:0];
                REG_WRAP_LOW:    wrap_low    = value;
                REG_WRAP_HIGH:   wrap_high   = value;
                default: ;
            endcase
        endfunction

        // Advances the packet position by one accepted byte. Returns 1 when the
        // byte carries azimuth or record content.
        function bit take_byte(logic [BYTE_W-1:0] d, logic start);
            int unsigned   p;
            int unsigned   rel;
            int unsigned   off;
            int unsigned   r;
            lidar_record_t rec;
            p = start ? 0 : byte_pos;
            byte_pos = (p < DATA_END) ? p + 1 : DATA_END;
            if (p < HEADER_BYTES_DEF || p >= DATA_END)
                return 1'b0;
            rel = p - HEADER_BYTES_DEF;
            off = rel % BLOCK_BYTES;
            if (off < 2)
                return 1'b0;
            if (off == 2) begin
                partial = {d, 8'h00};
            end else if (off == 3) begin
                cur_az     = {partial[15:8], d};
                turn       = seen_block && (cur_az < wrap_low) && (prev_az > wrap_high);
                prev_az    = cur_az;
                seen_block = 1'b1;
                rec_idx    = 0;
            end else begin
                r = off - 4;
                case (r % 3)
                    0: begin
                        rec_idx = r / 3;
                        partial = {d, 8'h00};
                    end
                    1: partial[7:0] = d;
                    default: begin
                        rec.azimuth   = cur_az;
                        rec.blk       = BLK_W'(rel / BLOCK_BYTES);
                        rec.firing    = 1'((rec_idx / CHANNELS_DEF) & 1);
                        rec.channel   = CH_W'(rec_idx % CHANNELS_DEF);
                        rec.turn      = turn;
                        // A high distance byte past the limit blanks the record.
                        if (partial[15:8] > range_limit) begin
                            rec.distance  = '0;
                            rec.intensity = '0;
                        end else begin
                            rec.distance  = partial;
                            rec.intensity = d;
                        end
                        pending_records.push_back(rec);
                    end
                endcase
            end
            return 1'b1;
        endfunction

        function void compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("record %0d %s got %0d expected %0d",
                                 checked, name, got, want));
        endfunction

        function void check_record(logic [M_TDATA_W-1:0] beat);
            lidar_record_t got;
            lidar_record_t want;
            if (pending_records.size() == 0) begin
                report($sformatf("unexpected record beat %h", beat));
                return;
            end
            want = pending_records.pop_front();
            got  = lidar_record_t'(beat[$bits(lidar_record_t)-1:0]);
            compare_field("azimuth", got.azimuth, want.azimuth);
            compare_field("block_number", got.blk, want.blk);
            compare_field("firing", got.firing, want.firing);
            compare_field("channel", got.channel, want.channel);
            compare_field("distance", got.distance, want.distance);
            compare_field("intensity", got.intensity, want.intensity);
            compare_field("turn_complete", got.turn, want.turn);
            compare_field("padding", beat[M_TDATA_W-1:$bits(lidar_record_t)], 0);
            checked++;
        endfunction

        function void flush_check();
            if (pending_records.size() != 0)
                report($sformatf("%0d expected records never arrived",
                                 pending_records.size()));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    record_tracker tracker = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_rx     = 1'b0;
    int  data_beats  = 0;
    int  quiet_cycles = 0;

    lidar_packet_record_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: random back-pressure, or one long hold when asked for.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD - 1) @(negedge aclk);
                hold_rx = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) < rx_idle_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_record(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(logic [BYTE_W-1:0] d, logic start);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        if (tracker.take_byte(d, start))
            data_beats++;
        @(negedge aclk);
    endtask

    task automatic send_header(logic start);
        for (int i = 0; i < HEADER_BYTES_DEF; i++)
            send_byte((i == 0) ? 8'hFF : BYTE_W'($urandom), start && (i == 0));
    endtask

    task automatic send_record(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
                               logic [BYTE_W-1:0] inten);
        send_byte(hi, 1'b0);
        send_byte(lo, 1'b0);
        send_byte(inten, 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending_records.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_register(addr, value);
        @(negedge aclk);
    endtask

    // Writes the registers only with the parser idle, after the last record has drained.
    task automatic load_settings(logic [BYTE_W-1:0] lim, logic [AZ_W-1:0] lo,
                                 logic [AZ_W-1:0] hi);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_RANGE_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_WRAP_LOW, lo);
        write_reg(REG_WRAP_HIGH, hi);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Azimuths cluster near both ends of the turn so wraps happen often.
    function automatic logic [AZ_W-1:0] pick_azimuth();
        case ($urandom_range(0, 5))
            0, 1:    return AZ_W'($urandom_range(0, 700));
            2, 3:    return AZ_W'($urandom_range(35300, 36000));
            4:       return AZ_W'($urandom_range(0, 35999));
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : AZ_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_range_high(logic [BYTE_W-1:0] limit);
        case ($urandom_range(0, 5))
            0:       return limit;
            1:       return limit + 8'd1;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 3))
            0:       return DATA_END;
            1:       return DATA_END + $urandom_range(1, 12);
            default: return $urandom_range(60, DATA_END - 1);
        endcase
    endfunction

    // Sends a well-formed packet with random content, cut short at the budget.
    // A rare stray packet start breaks the framing on purpose.
    task automatic send_packet(int length, int budget, bit pressure);
        int unsigned       off;
        logic [AZ_W-1:0]   az;
        logic [BYTE_W-1:0] d;
        logic              st;
        az = '0;
        for (int p = 0; p < length && data_beats < budget; p++) begin
            if (pressure && p == 500)
                hold_rx = 1'b1;
            if (pressure && p == 900)
                wait_drained();
            d = BYTE_W'($urandom);
            if (p >= HEADER_BYTES_DEF && p < DATA_END) begin
                off = (p - HEADER_BYTES_DEF) % BLOCK_BYTES;
                if (off == 2) begin
                    az = pick_azimuth();
                    d  = az[15:8];
                end else if (off == 3) begin
                    d = az[7:0];
                end else if (off >= 4 && (off - 4) % 3 == 0) begin
                    d = pick_range_high(tracker.range_limit);
                end
            end
            st = (p == 0) || (!pressure && $urandom_range(0, 999) == 0);
            send_byte(d, st);
        end
    endtask

    task automatic run_random_phase(int tx_pct, int rx_pct, logic [BYTE_W-1:0] lim,
                                    logic [AZ_W-1:0] lo, logic [AZ_W-1:0] hi);
        int budget;
        load_settings(lim, lo, hi);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        budget = data_beats + PHASE_BEATS;
        while (data_beats < budget)
            send_packet(pick_length(), budget, 1'b0);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Bytes before any packet start count as the start of a header.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_header(1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'h8C, 1'b0);
        send_byte(8'h9F, 1'b0);        // azimuth 35999, just short of a turn
        send_record(8'd120, 8'hFF, 8'hFF);
        send_record(8'd121, 8'h00, 8'hFF);
        send_record(8'hFF, 8'hFF, 8'hFF);
        send_record(8'h00, 8'h00, 8'h00);
        // A new packet start in mid-block restarts the packet; azimuth zero
        // after 35999 completes a turn.
        send_header(1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_record(8'h00, 8'h01, 8'h80);
        send_record(8'h78, 8'hFF, 8'h7F);

        run_random_phase(26, 55, 8'd255, 16'd36000, 16'd0);
        run_random_phase(55, 26, 8'd0, 16'd0, 16'd36000);

        // No idling: one full packet with trailing bytes, a long result hold
        // that backs up the input, and a pause until all records are out.
        load_settings(BYTE_W'($urandom), AZ_W'($urandom_range(0, 2000)),
                      AZ_W'($urandom_range(34000, 36000)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_packet(DATA_END + 10, 32'h7FFF_FFFF, 1'b1);

        wait_drained();
        repeat (8) @(posedge aclk);
        tracker.flush_check();
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lprp_pkg.sv
rtl/lprp_seq.sv
rtl/lprp_rec.sv
rtl/lidar_packet_record_parser_top.sv
verif/lidar_packet_record_parser_top_tb.sv
